>>> rtl/core/sfs_pkg.sv
// sprite frame sequencer package: widths, request and register codes,
// controller/datapath command and status structs; no dependencies
`timescale 1ns / 1ps

package sfs_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int POS_W      = $clog2(MAX_FRAMES);
  localparam int LEN_W      = $clog2(MAX_FRAMES + 1);
  localparam int DIV_W      = 32;
  localparam int ID_W       = 11;

  localparam int IN_TUSER_W  = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 80;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 24;

  // request kinds
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_LOAD = 2'd1;
  localparam logic [1:0] REQ_PLAY = 2'd2;
  localparam logic [1:0] REQ_STOP = 2'd3;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SHEET_COLUMNS = 3'd2;
  localparam logic [CFG_AW-1:0] REG_FRAME_PERIOD  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SPEED_SCALE   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_LOOP_ENABLE   = 3'd5;
  localparam logic [CFG_AW-1:0] REG_FLIP_MODE     = 3'd6;
  localparam logic [CFG_AW-1:0] REG_CLIP_LENGTH   = 3'd7;

  // register reset values
  localparam logic [11:0] RST_FRAME_WIDTH   = 12'd0;
  localparam logic [11:0] RST_FRAME_HEIGHT  = 12'd0;
  localparam logic [10:0] RST_SHEET_COLUMNS = 11'd1;
  localparam logic [23:0] RST_FRAME_PERIOD  = 24'd125000;
  localparam logic [15:0] RST_SPEED_SCALE   = 16'd256;
  localparam logic        RST_LOOP_ENABLE   = 1'b1;
  localparam logic [1:0]  RST_FLIP_MODE     = 2'd0;
  localparam logic [6:0]  RST_CLIP_LENGTH   = 7'd0;

  // divider operand selection
  localparam logic [1:0] DIV_TIME = 2'd0;
  localparam logic [1:0] DIV_WRAP = 2'd1;
  localparam logic [1:0] DIV_ID   = 2'd2;

  typedef struct packed {
    logic       latch_in;
    logic       load_wr;
    logic       play;
    logic       stop;
    logic       mul;
    logic       sum;
    logic       div_start;
    logic [1:0] div_sel;
    logic       save_time;
    logic       acc_sum;
    logic       wrap_set;
    logic       nl_adv;
    logic       nl_mul;
    logic       nl_end;
    logic       rd;
    logic       rect;
    logic       out_load;
  } sfs_cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       playing;
    logic       tick_go;
    logic       n_zero;
    logic       loop_en;
    logic       n_le_k;
    logic       rect_en;
    logic       div_done;
    logic       out_free;
  } sfs_sts_t;

endpackage

>>> rtl/core/sprite_frame_sequencer_top.sv
// sprite frame sequencer top level: controller plus datapath
// depends on sfs_pkg, sfs_ctrl, sfs_datapath
//
//   channel | ports                      | transaction
//   --------+----------------------------+------------------------------------
//   input   | in_tvalid/tready/tuser/tdata | one request: tick, load, play, stop
//   output  | out_tvalid/tready/tdata    | one status result per request
//   config  | cfg_we/addr/wdata          | one register write, no wait
//
// the input is ready again once the result of a request is loaded; a load, a
// stop or an ignored play goes straight to it, a play first computes the rectangle
// if it is enabled and a tick its time and rectangle steps, on the shared 32-step
// divider used for the period, the clip wrap and the sheet column split
// reset is synchronous, loads the register defaults and clears the clip state
// and the output valid flag; the frame table is not cleared
// a result waiting in the output register does not block the next request;
// that request then waits at its last step until the register is free
`timescale 1ns / 1ps

module sprite_frame_sequencer_top
  import sfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // req_type
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // delta_time, slot, frame_value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // src_x, src_y, src_w, src_h,
                                             // flip_bits, is_playing, frame_position
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata
);

  sfs_cmd_t cmd;
  sfs_sts_t sts;

  sfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

endmodule

>>> rtl/core/sfs_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module sfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/sfs_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on sfs_pkg
`timescale 1ns / 1ps

module sfs_div
  import sfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient,
  output logic [DIV_W-1:0] remainder
);

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] quo_r, rem_r, dvs_r;
  logic [DIV_W-1:0] quo_nxt, rem_nxt;
  logic [DIV_W:0]   shifted, trial;

  always_comb begin
    shifted = {rem_r, quo_r[DIV_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    if (!trial[DIV_W]) begin
      rem_nxt = trial[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DIV_W-1:0];
      quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> rtl/core/sfs_datapath.sv
// sequencer datapath: config registers, clip state, frame table, divider,
// rectangle and output register; depends on sfs_pkg, sfs_ram, sfs_div
`timescale 1ns / 1ps

module sfs_datapath
  import sfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  sfs_cmd_t               cmd,
  output sfs_sts_t               sts,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata
);

  // config
  logic [11:0] frame_width_r, frame_height_r;
  logic [10:0] sheet_columns_r;
  logic [23:0] frame_period_r;
  logic [15:0] speed_scale_r;
  logic        loop_enable_r;
  logic [1:0]  flip_mode_r;
  logic [6:0]  clip_length_r;

  // latched item
  logic [1:0]      req_r;
  logic [15:0]     delta_r;
  logic [5:0]      slot_r;
  logic [ID_W-1:0] value_r;

  // clip state
  logic [POS_W-1:0] pos_r;
  logic [31:0]      acc_r;
  logic             playing_r;
  logic [21:0]      src_x_r, src_y_r;
  logic [11:0]      src_w_r, src_h_r;

  // work registers
  logic [31:0] prod_r, sum_r, n_r, r_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [LEN_W-1:0] len_eff, pos_ext, k_val, k_inc, len_m1;
  logic [31:0]      dur, mul_dt;
  logic [LEN_W+31:0] nl_prod;
  logic [32:0]      add_full;
  logic [ID_W-1:0]  ram_rdata, id_val, cols;
  logic [POS_W-1:0] rd_idx;
  logic [DIV_W-1:0] div_a, div_b, div_q, div_rem;
  logic             div_done;
  logic [22:0]      x_prod, y_prod;
  logic             tbl_we;

  assign len_eff = (clip_length_r > LEN_W'(MAX_FRAMES)) ? LEN_W'(MAX_FRAMES) : clip_length_r;
  assign pos_ext = {1'b0, pos_r};
  assign len_m1  = len_eff - 1'b1;
  assign k_val   = ((pos_ext + 1'b1) < len_eff) ? (len_m1 - pos_ext) : '0;
  assign k_inc   = k_val + 1'b1;
  assign dur     = {frame_period_r, 8'h00};
  assign mul_dt  = delta_r * speed_scale_r;
  assign nl_prod = k_inc * dur;
  assign add_full = {1'b0, acc_r} + {1'b0, prod_r};

  // negative ids read as zero, zero columns as one
  assign id_val = ram_rdata[ID_W-1] ? '0 : ram_rdata;
  assign cols   = (sheet_columns_r == '0) ? 11'd1 : sheet_columns_r;
  assign rd_idx = (pos_ext < len_eff) ? pos_r : '0;

  assign x_prod = div_rem[10:0] * frame_width_r;
  assign y_prod = div_q[10:0] * frame_height_r;

  always_comb begin
    case (cmd.div_sel)
      DIV_TIME: begin
        div_a = sum_r;
        div_b = dur;
      end
      DIV_WRAP: begin
        div_a = (pos_ext >= len_eff) ? (n_r - 1'b1) : (n_r + DIV_W'(pos_r));
        div_b = DIV_W'(len_eff);
      end
      default: begin
        div_a = DIV_W'(id_val);
        div_b = DIV_W'(cols);
      end
    endcase
  end

  assign tbl_we = cmd.load_wr && (32'(slot_r) < MAX_FRAMES);

  sfs_ram #(
    .WIDTH(ID_W),
    .DEPTH(MAX_FRAMES)
  ) u_table (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(slot_r[POS_W-1:0]),
    .wdata(value_r),
    .re   (cmd.rd),
    .raddr(rd_idx),
    .rdata(ram_rdata)
  );

  sfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q),
    .remainder(div_rem)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= RST_FRAME_WIDTH;
      frame_height_r  <= RST_FRAME_HEIGHT;
      sheet_columns_r <= RST_SHEET_COLUMNS;
      frame_period_r  <= RST_FRAME_PERIOD;
      speed_scale_r   <= RST_SPEED_SCALE;
      loop_enable_r   <= RST_LOOP_ENABLE;
      flip_mode_r     <= RST_FLIP_MODE;
      clip_length_r   <= RST_CLIP_LENGTH;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_wdata[11:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata[11:0];
        REG_SHEET_COLUMNS: sheet_columns_r <= cfg_wdata[10:0];
        REG_FRAME_PERIOD:  frame_period_r  <= cfg_wdata[23:0];
        REG_SPEED_SCALE:   speed_scale_r   <= cfg_wdata[15:0];
        REG_LOOP_ENABLE:   loop_enable_r   <= cfg_wdata[0];
        REG_FLIP_MODE:     flip_mode_r     <= cfg_wdata[1:0];
        REG_CLIP_LENGTH:   clip_length_r   <= cfg_wdata[6:0];
      endcase
    end
  end

  // clip state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      acc_r     <= '0;
      playing_r <= 1'b0;
      src_x_r   <= '0;
      src_y_r   <= '0;
      src_w_r   <= '0;
      src_h_r   <= '0;
    end else begin
      if (cmd.play) begin
        pos_r     <= '0;
        acc_r     <= '0;
        playing_r <= 1'b1;
      end
      if (cmd.stop) begin
        playing_r <= 1'b0;
      end
      if (cmd.acc_sum) begin
        acc_r <= sum_r;
      end
      if (cmd.wrap_set) begin
        pos_r <= div_rem[POS_W-1:0];
        acc_r <= r_r;
      end
      if (cmd.nl_adv) begin
        pos_r <= pos_r + n_r[POS_W-1:0];
        acc_r <= r_r;
      end
      // ran past the last frame: park on it, keep leftover time
      if (cmd.nl_end) begin
        pos_r     <= len_m1[POS_W-1:0];
        playing_r <= 1'b0;
        acc_r     <= sum_r - prod_r;
      end
      if (cmd.rect) begin
        src_x_r <= x_prod[21:0];
        src_y_r <= y_prod[21:0];
        src_w_r <= frame_width_r;
        src_h_r <= frame_height_r;
      end
    end
  end

  // item latch and work registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r   <= in_tuser;
      delta_r <= in_tdata[15:0];
      slot_r  <= in_tdata[21:16];
      value_r <= in_tdata[32:22];
    end
    if (cmd.mul) begin
      prod_r <= mul_dt;
    end else if (cmd.nl_mul) begin
      prod_r <= nl_prod[31:0];
    end
    if (cmd.sum) begin
      sum_r <= add_full[32] ? 32'hFFFF_FFFF : add_full[31:0];
    end
    if (cmd.save_time) begin
      n_r <= div_q;
      r_r <= div_rem;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {3'b000, pos_r, playing_r, flip_mode_r,
                     src_h_r, src_w_r, src_y_r, src_x_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    sts.req      = req_r;
    sts.playing  = playing_r;
    sts.tick_go  = playing_r && (len_eff != '0) && (frame_period_r != '0);
    sts.n_zero   = (n_r == '0);
    sts.loop_en  = loop_enable_r;
    sts.n_le_k   = (n_r <= 32'(k_val));
    sts.rect_en  = (len_eff != '0) && (frame_width_r != '0) && (frame_height_r != '0);
    sts.div_done = div_done;
    sts.out_free = !out_valid_r || out_tready;
  end

endmodule

>>> rtl/core/sfs_ctrl.sv
// sequencer controller: walks one item through tick, wrap and rectangle steps
// depends on sfs_pkg
`timescale 1ns / 1ps

module sfs_ctrl
  import sfs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  sfs_sts_t sts,
  output sfs_cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DISP    = 4'd1;
  localparam logic [3:0] S_MUL     = 4'd2;
  localparam logic [3:0] S_SUM     = 4'd3;
  localparam logic [3:0] S_TSTART  = 4'd4;
  localparam logic [3:0] S_TWAIT   = 4'd5;
  localparam logic [3:0] S_TEVAL   = 4'd6;
  localparam logic [3:0] S_WWAIT   = 4'd7;
  localparam logic [3:0] S_NLEND   = 4'd8;
  localparam logic [3:0] S_RDADDR  = 4'd9;
  localparam logic [3:0] S_RDSTART = 4'd10;
  localparam logic [3:0] S_RDWAIT  = 4'd11;
  localparam logic [3:0] S_FIN     = 4'd12;

  logic [3:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.req)
          REQ_TICK: state_nxt = sts.tick_go ? S_MUL : S_RDADDR;
          REQ_LOAD: begin
            cmd.load_wr = 1'b1;
            state_nxt   = S_FIN;
          end
          REQ_PLAY: begin
            if (sts.playing) begin
              state_nxt = S_FIN;
            end else begin
              cmd.play  = 1'b1;
              state_nxt = S_RDADDR;
            end
          end
          REQ_STOP: begin
            cmd.stop  = 1'b1;
            state_nxt = S_FIN;
          end
        endcase
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_TSTART;
      end
      S_TSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_TIME;
        state_nxt     = S_TWAIT;
      end
      S_TWAIT: begin
        if (sts.div_done) begin
          cmd.save_time = 1'b1;
          state_nxt     = S_TEVAL;
        end
      end
      S_TEVAL: begin
        if (sts.n_zero) begin
          cmd.acc_sum = 1'b1;
          state_nxt   = S_RDADDR;
        end else if (sts.loop_en) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_WRAP;
          state_nxt     = S_WWAIT;
        end else if (sts.n_le_k) begin
          cmd.nl_adv = 1'b1;
          state_nxt  = S_RDADDR;
        end else begin
          cmd.nl_mul = 1'b1;
          state_nxt  = S_NLEND;
        end
      end
      S_WWAIT: begin
        cmd.div_sel = DIV_WRAP;
        if (sts.div_done) begin
          cmd.wrap_set = 1'b1;
          state_nxt    = S_RDADDR;
        end
      end
      S_NLEND: begin
        cmd.nl_end = 1'b1;
        state_nxt  = S_RDADDR;
      end
      S_RDADDR: begin
        if (sts.rect_en) begin
          cmd.rd    = 1'b1;
          state_nxt = S_RDSTART;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_RDSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_ID;
        state_nxt     = S_RDWAIT;
      end
      S_RDWAIT: begin
        cmd.div_sel = DIV_ID;
        if (sts.div_done) begin
          cmd.rect  = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> tb/sprite_frame_sequencer_top_tb.sv
// self-checking testbench for sprite_frame_sequencer_top: streaming requests in,
// one status result out per request, checked against a clip predictor
// depends on sfs_pkg and the sprite frame sequencer rtl
`timescale 1ns / 1ps

module sprite_frame_sequencer_top_tb;
  import sfs_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 120;

  // one result transaction, lowest field in the lowest bits
  typedef struct packed {
    logic [5:0]  position;
    logic        playing;
    logic [1:0]  flip;
    logic [11:0] h;
    logic [11:0] w;
    logic [21:0] y;
    logic [21:0] x;
  } frame_status_t;

  class clip_scoreboard;
    logic [10:0] frame_ids[MAX_FRAMES];
    int unsigned pos;
    longint unsigned acc;
    bit playing;
    logic [21:0] rect_x, rect_y;
    logic [11:0] rect_w, rect_h;
    logic [11:0] frame_w, frame_h;
    logic [10:0] columns;
    logic [23:0] period;
    logic [15:0] speed;
    logic loop_en;
    logic [1:0] flip;
    logic [6:0] clip_len;
    frame_status_t pending_frames[$];
    int mismatches;

    function new();
      pos = 0;
      acc = 0;
      playing = 0;
      rect_x = '0;
      rect_y = '0;
      rect_w = '0;
      rect_h = '0;
      frame_w = RST_FRAME_WIDTH;
      frame_h = RST_FRAME_HEIGHT;
      columns = RST_SHEET_COLUMNS;
      period = RST_FRAME_PERIOD;
      speed = RST_SPEED_SCALE;
      loop_en = RST_LOOP_ENABLE;
      flip = RST_FLIP_MODE;
      clip_len = RST_CLIP_LENGTH;
      mismatches = 0;
      foreach (frame_ids[i]) frame_ids[i] = '0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    function int pending();
      return pending_frames.size();
    endfunction

    function void write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
      case (addr)
        REG_FRAME_WIDTH:   frame_w = data[11:0];
        REG_FRAME_HEIGHT:  frame_h = data[11:0];
        REG_SHEET_COLUMNS: columns = data[10:0];
        REG_FRAME_PERIOD:  period = data[23:0];
        REG_SPEED_SCALE:   speed = data[15:0];
        REG_LOOP_ENABLE:   loop_en = data[0];
        REG_FLIP_MODE:     flip = data[1:0];
        default:           clip_len = data[6:0];
      endcase
    endfunction

    function int unsigned used_length();
      return (clip_len > MAX_FRAMES) ? MAX_FRAMES : 32'(clip_len);
    endfunction

    function void refresh_rect();
      int unsigned len, idx, id, cols;
      len = used_length();
      if (len == 0 || frame_w == 0 || frame_h == 0) return;
      idx = (pos < len) ? pos : 0;
      // negative sheet ids show frame 0
      id = frame_ids[idx][10] ? 0 : 32'(frame_ids[idx]);
      cols = (columns == 0) ? 1 : 32'(columns);
      rect_x = 22'((id % cols) * frame_w);
      rect_y = 22'((id / cols) * frame_h);
      rect_w = frame_w;
      rect_h = frame_h;
    endfunction

    function void advance_time(logic [15:0] delta);
      int unsigned len;
      longint unsigned total, span, steps, rest, room;
      len = used_length();
      if (!playing || len == 0 || period == 0) return;
      total = acc + 64'(delta) * 64'(speed);
      if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
      span = 64'(period) << 8;
      steps = total / span;
      rest = total % span;
      if (steps == 0) begin
        acc = total;
      end else if (loop_en) begin
        if (pos >= len) pos = int'((steps - 1) % len);
        else pos = int'((pos + steps) % len);
        acc = rest;
      end else begin
        room = (pos + 1 < len) ? 64'(len - 1 - pos) : 64'd0;
        if (steps <= room) begin
          pos = pos + int'(steps);
          acc = rest;
        end else begin
          // runs off the end: room + 1 periods used, remainder kept
          pos = len - 1;
          playing = 0;
          acc = total - (room + 1) * span;
        end
      end
    endfunction

    function void note_request(logic [1:0] kind, logic [15:0] delta, logic [5:0] slot,
                               logic [10:0] id);
      frame_status_t exp_frame;
      case (kind)
        REQ_TICK: begin
          advance_time(delta);
          refresh_rect();
        end
        REQ_LOAD: frame_ids[slot] = id;
        REQ_PLAY: begin
          if (!playing) begin
            pos = 0;
            acc = 0;
            playing = 1;
            refresh_rect();
          end
        end
        default: playing = 0;
      endcase
      exp_frame.x = rect_x;
      exp_frame.y = rect_y;
      exp_frame.w = rect_w;
      exp_frame.h = rect_h;
      exp_frame.flip = flip;
      exp_frame.playing = playing;
      exp_frame.position = 6'(pos);
      pending_frames = {pending_frames, exp_frame};
    endfunction

    task check_result(logic [OUT_TDATA_W-1:0] data);
      frame_status_t got, want;
      got = frame_status_t'(data[$bits(frame_status_t)-1:0]);
      if (pending_frames.size() == 0) begin
        report($sformatf("result with nothing expected: %h", data));
      end else begin
        want = pending_frames.pop_front();
        if (got.x != want.x) report($sformatf("src_x %0d, expected %0d", got.x, want.x));
        if (got.y != want.y) report($sformatf("src_y %0d, expected %0d", got.y, want.y));
        if (got.w != want.w) report($sformatf("src_w %0d, expected %0d", got.w, want.w));
        if (got.h != want.h) report($sformatf("src_h %0d, expected %0d", got.h, want.h));
        if (got.flip != want.flip)
          report($sformatf("flip_bits %0d, expected %0d", got.flip, want.flip));
        if (got.playing != want.playing)
          report($sformatf("is_playing %0d, expected %0d", got.playing, want.playing));
        if (got.position != want.position)
          report($sformatf("frame_position %0d, expected %0d", got.position, want.position));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // req_type
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // delta_time, slot, frame_value
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // src_x, src_y, src_w, src_h,
                                           // flip_bits, is_playing, frame_position
  logic                   cfg_we = 1'b0;
  logic [CFG_AW-1:0]      cfg_addr = '0;
  logic [CFG_DW-1:0]      cfg_wdata = '0;

  clip_scoreboard sb = new();
  bit burst_mode = 0;
  bit hold_req = 0;
  int hold_left = 0;
  int cycle_count = 0;

  sprite_frame_sequencer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: check, then decide readiness for the next cycle
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= burst_mode || ($urandom_range(99) >= 35);
      end
    end
  end

  task automatic send_req(logic [1:0] kind, logic [15:0] delta, logic [5:0] slot,
                          logic [10:0] id);
    while (!burst_mode && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {7'd0, id, slot, delta};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(kind, delta, slot, id);
  endtask

  task automatic tick(logic [15:0] delta);
    send_req(REQ_TICK, delta, 6'($urandom_range(63)), 11'($urandom_range(2047)));
  endtask

  task automatic load(logic [5:0] slot, logic [10:0] id);
    send_req(REQ_LOAD, 16'($urandom_range(65535)), slot, id);
  endtask

  task automatic play();
    send_req(REQ_PLAY, 16'($urandom_range(65535)), 6'($urandom_range(63)),
             11'($urandom_range(2047)));
  endtask

  task automatic stop();
    send_req(REQ_STOP, 16'($urandom_range(65535)), 6'($urandom_range(63)),
             11'($urandom_range(2047)));
  endtask

  // sender waits for every result, then lets the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(addr, data);
  endtask

  task automatic set_clip(int w, int h, int cols, int per, int spd, int lp, int flp,
                          int len);
    write_reg(REG_FRAME_WIDTH, CFG_DW'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DW'(h));
    write_reg(REG_SHEET_COLUMNS, CFG_DW'(cols));
    write_reg(REG_FRAME_PERIOD, CFG_DW'(per));
    write_reg(REG_SPEED_SCALE, CFG_DW'(spd));
    write_reg(REG_LOOP_ENABLE, CFG_DW'(lp));
    write_reg(REG_FLIP_MODE, CFG_DW'(flp));
    write_reg(REG_CLIP_LENGTH, CFG_DW'(len));
    cfg_we <= 1'b0;
  endtask

  function automatic int pick(int lo, int hi, int zero_pct, int top_val, int top_pct);
    int r;
    r = $urandom_range(99);
    if (r < zero_pct) return 0;
    if (r < zero_pct + top_pct) return top_val;
    return $urandom_range(hi, lo);
  endfunction

  function automatic logic [15:0] pick_delta();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 16'd0;
    if (r < 10) return 16'hFFFF;
    if (r < 40) return 16'($urandom_range(2000));
    return 16'($urandom_range(65535));
  endfunction

  task automatic random_clip();
    set_clip(pick(1, 256, 12, 4095, 8), pick(1, 256, 12, 4095, 8),
             pick(1, 40, 10, 1024, 10), pick(1, 5000, 8, 16777215, 5),
             pick(32, 1024, 5, 65535, 5), $urandom_range(1), $urandom_range(3),
             pick(1, 20, 8, 64, 12));
  endtask

  // mostly play-then-tick runs with the odd load, replay and stop
  task automatic run_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 58) tick(pick_delta());
      else if (r < 73) load(6'($urandom_range(63)), 11'($urandom_range(2047)));
      else if (r < 90) play();
      else stop();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: empty clip, rectangle disabled
    tick(16'hFFFF);
    play();
    tick(16'hFFFF);
    play();
    stop();
    drain();

    // fill the whole table so no unwritten entry is ever read
    for (int s = 0; s < MAX_FRAMES; s++) load(6'(s), 11'($urandom_range(2047)));
    load(6'd0, 11'h400);
    load(6'd63, 11'h3FF);
    drain();

    set_clip(4095, 4095, 0, 1, 256, 1, 3, 64);
    play();
    tick(16'd63);
    tick(16'hFFFF);
    drain();
    // position now past a shorter clip: looping restart
    set_clip(4095, 4095, 1024, 1, 256, 1, 2, 3);
    tick(16'd5);
    drain();
    set_clip(100, 7, 3, 1, 256, 1, 1, 64);
    tick(16'd60);
    drain();
    // past the end of a shorter clip without looping
    set_clip(100, 7, 3, 1, 256, 0, 1, 3);
    tick(16'd1);
    play();
    tick(16'd2);
    tick(16'd1);
    play();
    stop();
    tick(16'd9);
    drain();
    // accumulator saturation
    set_clip(12, 34, 5, 16777215, 65535, 1, 0, 64);
    play();
    tick(16'hFFFF);
    tick(16'hFFFF);
    tick(16'hFFFF);
    drain();

    for (int p = 0; p < 10; p++) begin
      random_clip();
      burst_mode = (p == 1);
      if (p == 4) hold_req = 1;
      run_phase(46);
      drain();
    end
    burst_mode = 0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
